FILE: hdl/tmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmt_pkg;

  localparam logic [2:0] MODE_ADD   = 3'd0;
  localparam logic [2:0] MODE_DEL   = 3'd1;
  localparam logic [2:0] MODE_TTIME = 3'd2;
  localparam logic [2:0] MODE_NEXT  = 3'd3;
  localparam logic [2:0] MODE_TEMPO = 3'd4;
  localparam logic [2:0] MODE_TTICK = 3'd5;

  localparam logic [31:0] RESET_TEMPO  = 32'd2236962;
  localparam int unsigned SEARCH_START = 256;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] tick;
    logic [31:0] tempo;
    logic [63:0] time_req;
  } cmd_t;

  typedef struct packed {
    logic [63:0] time_out;
    logic [31:0] tick_out;
    logic [31:0] tempo_out;
    logic        found;
    logic        table_full;
  } res_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tmt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module tmt_cell
  import tmt_pkg::*;
#(
  parameter int TB = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          shift_i,
  input  wire logic [TB-1:0] tick_i,
  input  wire logic [31:0]   tempo_i,
  input  wire logic          wr_tempo_i,
  input  wire logic [31:0]   wr_data_i,
  output logic      [TB-1:0] tick_o,
  output logic      [31:0]   tempo_o
);

  logic [TB-1:0] tick_q, tick_d;
  logic [31:0]   tempo_q, tempo_d;

  always_comb begin
    tick_d  = tick_q;
    tempo_d = tempo_q;
    if (shift_i) begin
      tick_d  = tick_i;
      tempo_d = tempo_i;
    end else if (wr_tempo_i) begin
      tempo_d = wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      tempo_q <= RESET_TEMPO;
    end else begin
      tick_q  <= tick_d;
      tempo_q <= tempo_d;
    end
  end

  assign tick_o  = tick_q;
  assign tempo_o = tempo_q;

endmodule

`default_nettype wire

FILE: hdl/tmt_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module tmt_mac
  import tmt_pkg::*;
#(
  parameter int TB = 32
) (
  input  wire logic          clk_i,
  input  wire logic          clr_i,
  input  wire logic          en_i,
  input  wire logic [TB-1:0] diff_i,
  input  wire logic [31:0]   rate_i,
  output logic      [63:0]   acc_o
);

  localparam int MW = (TB + 32 > 65) ? TB + 32 : 65;

  logic [MW-1:0] prod_full;
  logic [63:0]   prod_q, prod_d;
  logic [63:0]   acc_q, acc_d;

  always_comb begin
    prod_full = MW'(diff_i) * MW'(rate_i);
    prod_d    = '0;
    if (en_i && !clr_i) begin
      prod_d = (|prod_full[MW-1:64]) ? {64{1'b1}} : prod_full[63:0];
    end
    acc_d = clr_i ? 64'd0 : sat_add(acc_q, prod_q);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

FILE: hdl/tempo_map_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Tempo map: a sorted list of tempo marks held in a ring of cells.
// Commands enter on cmd_i when start is high and busy is low; the transfer
// happens at that clock edge. Each command gives exactly one result on
// res_o, marked by done_o for one cycle; the receiver cannot hold it off,
// so it must take every result in the cycle it appears.
// The initial tempo (tempo of the mark at tick zero) is written through
// cfg_valid_i/cfg_ready_o/cfg_data_i; ready is high only while idle.
// Every operation rotates the whole ring once past the head logic, one
// cell per cycle; after the pass the FIN and SUM states finish the
// running sum. For add, delete, tick-to-time, next-mark and read-tempo,
// done_o rises in the DONE state that follows SUM; the next command can
// transfer only once the block is back in IDLE after the result cycle.
// Time-to-tick evaluates the time at one tick per pass; after each pass
// the DECIDE state grows the search bracket or narrows it, and each
// binary step also passes through BCHK; with 32-bit ticks that is at most
// 7 growing passes and 32 binary passes. busy stays high through the result
// cycle. After reset the table holds one mark at tick zero with the default
// tempo, and the block is idle.
module tempo_map_table
  import tmt_pkg::*;
#(
  parameter int MAX_MARKS = 64,
  parameter int TICK_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire cmd_t        cmd_i,
  output logic             done_o,
  output res_t             res_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  localparam int TB = TICK_BITS;
  localparam int N  = MAX_MARKS;
  localparam int CW = $clog2(N + 1);
  localparam int BW = TB + 4;
  localparam logic [TB-1:0] TICK_MAX = {TB{1'b1}};

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PASS   = 3'd1;
  localparam logic [2:0] ST_FIN    = 3'd2;
  localparam logic [2:0] ST_SUM    = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_BCHK   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0] state_q, state_d;

  logic [TB-1:0] cell_tick [N];
  logic [31:0]   cell_tempo [N];
  logic [TB-1:0] wr_tick;
  logic [31:0]   wr_tempo;

  logic [2:0]    op_q, op_d;
  logic [TB-1:0] tk_q, tk_d;
  logic [31:0]   tempo_q, tempo_d;
  logic [63:0]   treq_q, treq_d;
  logic [TB-1:0] qk_q, qk_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] j_q, j_d;
  logic          ins_q, ins_d, del_q, del_d, match_q, match_d;
  logic [TB-1:0] car_tick_q, car_tick_d;
  logic [31:0]   car_tempo_q, car_tempo_d;
  logic [TB-1:0] seg_tick_q, seg_tick_d;
  logic [31:0]   seg_tempo_q, seg_tempo_d;
  logic [31:0]   tres_q, tres_d;
  logic [TB-1:0] kres_q, kres_d;
  logic          full_q, full_d;
  logic [TB-1:0] a_q, a_d;
  logic [BW-1:0] b_q, b_d;
  logic [63:0]   ta_q, ta_d, tb_q, tb_d;
  logic          bin_q, bin_d, clamp_q, clamp_d;

  logic          launch, shift, mac_en;
  logic [TB-1:0] mac_diff;
  logic [31:0]   mac_rate;
  logic [63:0]   acc;
  logic          in_range;
  logic [TB-1:0] in_tick;
  logic [31:0]   in_tempo;
  logic [BW-1:0] nb, mid;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign shift       = (state_q == ST_PASS);

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [TB-1:0] nxt_tick;
    logic [31:0]   nxt_tempo;
    if (k == N - 1) begin : g_tail
      assign nxt_tick  = wr_tick;
      assign nxt_tempo = wr_tempo;
    end else begin : g_mid
      assign nxt_tick  = cell_tick[k+1];
      assign nxt_tempo = cell_tempo[k+1];
    end
    tmt_cell #(.TB(TB)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (shift),
      .tick_i     (nxt_tick),
      .tempo_i    (nxt_tempo),
      .wr_tempo_i ((k == 0) && cfg_valid_i && cfg_ready_o),
      .wr_data_i  (cfg_data_i),
      .tick_o     (cell_tick[k]),
      .tempo_o    (cell_tempo[k])
    );
  end

  tmt_mac #(.TB(TB)) u_mac (
    .clk_i  (clk_i),
    .clr_i  (launch),
    .en_i   (mac_en),
    .diff_i (mac_diff),
    .rate_i (mac_rate),
    .acc_o  (acc)
  );

  assign in_tick  = cell_tick[0];
  assign in_tempo = cell_tempo[0];
  assign in_range = (j_q < cnt_q);

  // Head of the ring: looks at one mark per cycle and writes the tail.
  always_comb begin
    wr_tick      = in_tick;
    wr_tempo     = in_tempo;
    ins_d        = ins_q;
    del_d        = del_q;
    match_d      = match_q;
    car_tick_d   = car_tick_q;
    car_tempo_d  = car_tempo_q;
    seg_tick_d   = seg_tick_q;
    seg_tempo_d  = seg_tempo_q;
    tres_d       = tres_q;
    kres_d       = kres_q;
    mac_en       = 1'b0;
    mac_diff     = in_tick - seg_tick_q;
    mac_rate     = seg_tempo_q;
    if (state_q == ST_PASS) begin
      if (j_q == '0) begin
        seg_tick_d  = in_tick;
        seg_tempo_d = in_tempo;
      end else if (in_range && (in_tick < qk_q)) begin
        mac_en      = 1'b1;
        seg_tick_d  = in_tick;
        seg_tempo_d = in_tempo;
      end
      if (in_range && (in_tick <= tk_q)) begin
        tres_d = in_tempo;
      end
      unique case (op_q)
        MODE_ADD: begin
          if (ins_q) begin
            wr_tick     = car_tick_q;
            wr_tempo    = car_tempo_q;
            car_tick_d  = in_tick;
            car_tempo_d = in_tempo;
          end else if (in_range && (in_tick == tk_q)) begin
            wr_tempo = tempo_q;
            match_d  = 1'b1;
          end else if (!match_q && (cnt_q != CW'(N)) && (!in_range || (in_tick > tk_q))) begin
            wr_tick     = tk_q;
            wr_tempo    = tempo_q;
            car_tick_d  = in_tick;
            car_tempo_d = in_tempo;
            ins_d       = 1'b1;
          end
        end
        MODE_DEL: begin
          // Once the mark is dropped every later cell moves up by one.
          if (del_q || ((tk_q != '0) && (j_q != '0) && in_range && (in_tick == tk_q))) begin
            wr_tick  = cell_tick[1];
            wr_tempo = cell_tempo[1];
            del_d    = 1'b1;
            match_d  = 1'b1;
          end
        end
        MODE_NEXT: begin
          if (in_range && !match_q && (in_tick > tk_q)) begin
            kres_d  = in_tick;
            match_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (state_q == ST_FIN) begin
      mac_en   = 1'b1;
      mac_diff = qk_q - seg_tick_q;
    end
  end

  always_comb begin
    state_d = state_q;
    launch  = 1'b0;
    op_d    = op_q;
    tk_d    = tk_q;
    tempo_d = tempo_q;
    treq_d  = treq_q;
    qk_d    = qk_q;
    cnt_d   = cnt_q;
    j_d     = j_q;
    full_d  = full_q;
    a_d     = a_q;
    b_d     = b_q;
    ta_d    = ta_q;
    tb_d    = tb_q;
    bin_d   = bin_q;
    clamp_d = clamp_q;
    nb      = b_q << 4;
    mid     = BW'(a_q) + ((b_q - BW'(a_q)) >> 1);
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d    = cmd_i.mode;
          tk_d    = TB'(cmd_i.tick);
          tempo_d = cmd_i.tempo;
          treq_d  = cmd_i.time_req;
          full_d  = 1'b0;
          a_d     = '0;
          b_d     = BW'(SEARCH_START);
          ta_d    = '0;
          bin_d   = 1'b0;
          clamp_d = 1'b0;
          qk_d    = (cmd_i.mode == MODE_TTICK) ? TB'(SEARCH_START) : TB'(cmd_i.tick);
          launch  = 1'b1;
          state_d = ST_PASS;
        end
      end
      ST_PASS: begin
        j_d = j_q + CW'(1);
        if (j_q == CW'(N - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (ins_q) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (del_q) begin
          cnt_d = cnt_q - CW'(1);
        end
        full_d  = (op_q == MODE_ADD) && (cnt_q == CW'(N)) && !match_q;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        state_d = (op_q == MODE_TTICK) ? ST_DECIDE : ST_DONE;
      end
      ST_DECIDE: begin
        if (bin_q) begin
          if (acc > treq_q) begin
            b_d  = BW'(qk_q);
            tb_d = acc;
          end else begin
            a_d  = qk_q;
            ta_d = acc;
          end
          state_d = ST_BCHK;
        end else if (clamp_q) begin
          if (acc <= treq_q) begin
            a_d     = TICK_MAX;
            b_d     = BW'(TICK_MAX);
            ta_d    = acc;
            tb_d    = acc;
            state_d = ST_BCHK;
          end else begin
            tb_d    = acc;
            bin_d   = 1'b1;
            state_d = ST_BCHK;
          end
        end else if (acc > treq_q) begin
          tb_d    = acc;
          bin_d   = 1'b1;
          state_d = ST_BCHK;
        end else begin
          if (nb >= BW'(TICK_MAX)) begin
            b_d     = BW'(TICK_MAX);
            qk_d    = TICK_MAX;
            clamp_d = 1'b1;
          end else begin
            b_d  = nb;
            qk_d = nb[TB-1:0];
          end
          launch  = 1'b1;
          state_d = ST_PASS;
        end
      end
      ST_BCHK: begin
        if ((BW'(a_q) + BW'(1)) < b_q) begin
          qk_d    = mid[TB-1:0];
          bin_d   = 1'b1;
          launch  = 1'b1;
          state_d = ST_PASS;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (launch) begin
      j_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= CW'(1);
      j_q     <= '0;
      ins_q   <= 1'b0;
      del_q   <= 1'b0;
      match_q <= 1'b0;
      bin_q   <= 1'b0;
      clamp_q <= 1'b0;
      op_q    <= MODE_ADD;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      j_q     <= j_d;
      ins_q   <= launch ? 1'b0 : ins_d;
      del_q   <= launch ? 1'b0 : del_d;
      match_q <= launch ? 1'b0 : match_d;
      bin_q   <= bin_d;
      clamp_q <= clamp_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tk_q        <= tk_d;
    tempo_q     <= tempo_d;
    treq_q      <= treq_d;
    qk_q        <= qk_d;
    car_tick_q  <= car_tick_d;
    car_tempo_q <= car_tempo_d;
    seg_tick_q  <= seg_tick_d;
    seg_tempo_q <= seg_tempo_d;
    tres_q      <= tres_d;
    kres_q      <= launch ? '0 : kres_d;
    full_q      <= full_d;
    a_q         <= a_d;
    b_q         <= b_d;
    ta_q        <= ta_d;
    tb_q        <= tb_d;
  end

  logic [TB-1:0] near;
  assign near = ((treq_q - ta_q) >= (tb_q - treq_q)) ? b_q[TB-1:0] : a_q;

  always_comb begin
    res_o = '0;
    unique case (op_q)
      MODE_ADD:   res_o.table_full = full_q;
      MODE_DEL:   res_o.found      = match_q;
      MODE_TTIME: res_o.time_out   = acc;
      MODE_NEXT: begin
        res_o.found    = match_q;
        res_o.tick_out = 32'(kres_q);
      end
      MODE_TEMPO: res_o.tempo_out = tres_q;
      MODE_TTICK: res_o.tick_out  = 32'(near);
      default: begin
      end
    endcase
  end

  assign done_o = (state_q == ST_DONE);

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= CW'(N)))
    else $error("mark count out of range");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == ST_SUM) || ($past(state_q) == ST_BCHK))
    else $error("result without finished evaluation");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command transfer did not make the block busy");

  a_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BCHK) |-> (BW'(a_q) <= b_q))
    else $error("search bracket inverted");

  a_one_edit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ins_q && del_q))
    else $error("insert and delete in the same pass");

endmodule

`default_nettype wire

FILE: tb/tempo_map_table_test.sv
`timescale 1ns / 1ps

module tempo_map_table_test;
  import tmt_pkg::*;

  localparam int NMARKS = 64;
  localparam logic [63:0] TICK_TOP = 64'hFFFF_FFFF;
  localparam int SETTLE = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd_i = '0;
  logic done_o;
  res_t res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  tempo_map_table i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd_i),
    .done_o(done_o), .res_o(res_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // Predicted copy of the tempo map.
  logic [63:0] map_ticks[NMARKS];
  logic [31:0] map_tempos[NMARKS];
  int unsigned map_count;

  cmd_t pending_cmds[$];
  logic [31:0] pending_tempo_writes[$];
  res_t expected_results[$];
  int errors = 0;
  logic cmd_active = 1'b0;
  int gap_left = 0;
  logic feeding_done = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic [63:0] mul_sat(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return (p[127:64] != 0) ? {64{1'b1}} : p[63:0];
  endfunction

  function automatic logic [63:0] elapsed_at(input logic [63:0] tk);
    logic [63:0] total, seg_tick;
    logic [31:0] seg_tempo;
    total = 0;
    seg_tick = 0;
    seg_tempo = map_tempos[0];
    for (int i = 1; i < map_count && map_ticks[i] < tk; i++) begin
      total = add_sat(total, mul_sat(map_ticks[i] - seg_tick, {32'd0, seg_tempo}));
      seg_tick = map_ticks[i];
      seg_tempo = map_tempos[i];
    end
    return add_sat(total, mul_sat(tk - seg_tick, {32'd0, seg_tempo}));
  endfunction

  function automatic logic [63:0] nearest_tick_of(input logic [63:0] t);
    logic [63:0] a, b, m, ta, tb;
    a = 0;
    b = SEARCH_START;
    forever begin
      if (b >= TICK_TOP) begin
        b = TICK_TOP;
        if (elapsed_at(b) <= t) return b;
        break;
      end
      if (elapsed_at(b) > t) break;
      b = b << 4;
    end
    while (a + 1 < b) begin
      m = a + ((b - a) >> 1);
      if (elapsed_at(m) > t) b = m;
      else a = m;
    end
    ta = elapsed_at(a);
    tb = elapsed_at(b);
    return (t - ta >= tb - t) ? b : a;
  endfunction

  function automatic res_t apply_cmd(input cmd_t c);
    res_t r;
    int i;
    logic [63:0] tk;
    logic [63:0] nt;
    r = '0;
    tk = {32'd0, c.tick};
    case (c.mode)
      MODE_ADD: begin
        i = 0;
        while (i < map_count && map_ticks[i] < tk) i++;
        if (i < map_count && map_ticks[i] == tk) begin
          map_tempos[i] = c.tempo;
        end else if (map_count >= NMARKS) begin
          r.table_full = 1'b1;
        end else begin
          for (int j = map_count; j > i; j--) begin
            map_ticks[j] = map_ticks[j-1];
            map_tempos[j] = map_tempos[j-1];
          end
          map_ticks[i] = tk;
          map_tempos[i] = c.tempo;
          map_count++;
        end
      end
      MODE_DEL: begin
        if (tk != 0) begin
          for (i = 1; i < map_count; i++) begin
            if (map_ticks[i] == tk) begin
              for (int j = i; j < map_count - 1; j++) begin
                map_ticks[j] = map_ticks[j+1];
                map_tempos[j] = map_tempos[j+1];
              end
              map_count--;
              r.found = 1'b1;
              break;
            end
          end
        end
      end
      MODE_TTIME: r.time_out = elapsed_at(tk);
      MODE_NEXT: begin
        for (i = 0; i < map_count; i++) begin
          if (map_ticks[i] > tk) begin
            r.tick_out = map_ticks[i][31:0];
            r.found = 1'b1;
            break;
          end
        end
      end
      MODE_TEMPO: begin
        r.tempo_out = map_tempos[0];
        for (i = 1; i < map_count && map_ticks[i] <= tk; i++) r.tempo_out = map_tempos[i];
      end
      MODE_TTICK: begin
        nt = nearest_tick_of(c.time_req);
        r.tick_out = nt[31:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Driver: one command per transfer, predicted at the accepting edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_results.insert(expected_results.size(), apply_cmd(cmd_i));
        cmd_active <= 1'b0;
        start <= 1'b0;
        gap_left <= pick_gap();
      end else if (!cmd_active && !start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_cmds.size() > 0) begin
          cmd_i <= pending_cmds.pop_front();
          start <= 1'b1;
          cmd_active <= 1'b1;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        map_tempos[0] = cfg_data_i;
        cfg_valid_i <= 1'b0;
      end else if (!cfg_valid_i && pending_tempo_writes.size() > 0) begin
        cfg_data_i <= pending_tempo_writes.pop_front();
        cfg_valid_i <= 1'b1;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_o);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (res_o.time_out !== exp_r.time_out) begin
          $display("%0t: time_out expected %h actual %h", $time, exp_r.time_out,
                   res_o.time_out);
          errors++;
        end
        if (res_o.tick_out !== exp_r.tick_out) begin
          $display("%0t: tick_out expected %h actual %h", $time, exp_r.tick_out,
                   res_o.tick_out);
          errors++;
        end
        if (res_o.tempo_out !== exp_r.tempo_out) begin
          $display("%0t: tempo_out expected %h actual %h", $time, exp_r.tempo_out,
                   res_o.tempo_out);
          errors++;
        end
        if (res_o.found !== exp_r.found) begin
          $display("%0t: found expected %b actual %b", $time, exp_r.found, res_o.found);
          errors++;
        end
        if (res_o.table_full !== exp_r.table_full) begin
          $display("%0t: table_full expected %b actual %b", $time, exp_r.table_full,
                   res_o.table_full);
          errors++;
        end
      end
    end
  end

  function automatic cmd_t make_cmd(input logic [2:0] m, input logic [31:0] tk,
                                    input logic [31:0] tp, input logic [63:0] tq);
    cmd_t c;
    c.mode = m;
    c.tick = tk;
    c.tempo = tp;
    c.time_req = tq;
    return c;
  endfunction

  function automatic void queue_cmd(input cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic logic [31:0] rand_tick();
    int p;
    p = $urandom_range(0, 9);
    if (p < 5) return $urandom_range(0, 4000);
    if (p < 7) return $urandom_range(0, 300) * 16;
    if (p < 9) return $urandom();
    return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
  endfunction

  function automatic logic [31:0] rand_tempo();
    int p;
    p = $urandom_range(0, 9);
    if (p < 6) return $urandom_range(1_000_000, 10_000_000);
    if (p < 8) return $urandom();
    return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
  endfunction

  function automatic logic [63:0] rand_time();
    int p;
    p = $urandom_range(0, 9);
    if (p < 6) return {32'd0, $urandom()} * $urandom_range(1, 4000);
    if (p < 8) return {$urandom(), $urandom()};
    return $urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0;
  endfunction

  function automatic cmd_t rand_cmd();
    int p;
    p = $urandom_range(0, 99);
    if (p < 30) return make_cmd(MODE_ADD, rand_tick(), rand_tempo(), rand_time());
    if (p < 45) return make_cmd(MODE_DEL, (map_count > 1 && $urandom_range(0, 1)) ?
                                map_ticks[$urandom_range(1, map_count - 1)][31:0] :
                                rand_tick(), rand_tempo(), rand_time());
    if (p < 60) return make_cmd(MODE_TTIME, rand_tick(), rand_tempo(), rand_time());
    if (p < 72) return make_cmd(MODE_NEXT, rand_tick(), rand_tempo(), rand_time());
    if (p < 84) return make_cmd(MODE_TEMPO, rand_tick(), rand_tempo(), rand_time());
    if (p < 97) return make_cmd(MODE_TTICK, rand_tick(), rand_tempo(), rand_time());
    return make_cmd(3'($urandom_range(6, 7)), rand_tick(), rand_tempo(), rand_time());
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || cmd_active || expected_results.size() > 0
           || pending_tempo_writes.size() > 0 || cfg_valid_i)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_tempo(input logic [31:0] v);
    wait_drained();
    pending_tempo_writes.insert(pending_tempo_writes.size(), v);
    wait_drained();
  endtask

  initial begin
    map_ticks[0] = 0;
    map_tempos[0] = RESET_TEMPO;
    map_count = 1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every operation, field extremes, replace at tick zero, absent deletes.
    queue_cmd(make_cmd(MODE_TEMPO, 32'd0, 32'd0, 64'd0));
    queue_cmd(make_cmd(MODE_NEXT, 32'd0, 32'd0, 64'd0));
    queue_cmd(make_cmd(MODE_TTICK, 32'd0, 32'd0, 64'd0));
    queue_cmd(make_cmd(MODE_TTICK, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    queue_cmd(make_cmd(MODE_TTIME, 32'hFFFF_FFFF, 32'd0, 64'd0));
    queue_cmd(make_cmd(MODE_ADD, 32'd480, 32'hFFFF_FFFF, 64'd0));
    queue_cmd(make_cmd(MODE_ADD, 32'd960, 32'd1000, 64'd0));
    queue_cmd(make_cmd(MODE_ADD, 32'hFFFF_FFFF, 32'd7, 64'hFFFF_FFFF_FFFF_FFFF));
    queue_cmd(make_cmd(MODE_ADD, 32'd0, 32'd3000000, 64'd0));
    queue_cmd(make_cmd(MODE_ADD, 32'd960, 32'd5000, 64'd0));
    queue_cmd(make_cmd(MODE_TTIME, 32'hFFFF_FFFF, 32'd0, 64'd0));
    queue_cmd(make_cmd(MODE_TTIME, 32'd700, 32'd0, 64'd0));
    queue_cmd(make_cmd(MODE_NEXT, 32'd480, 32'd0, 64'd0));
    queue_cmd(make_cmd(MODE_NEXT, 32'hFFFF_FFFF, 32'd0, 64'd0));
    queue_cmd(make_cmd(MODE_TEMPO, 32'd960, 32'd0, 64'd0));
    queue_cmd(make_cmd(MODE_TTICK, 32'd0, 32'd0, 64'd1_000_000_000));
    queue_cmd(make_cmd(MODE_TTICK, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    queue_cmd(make_cmd(MODE_DEL, 32'd0, 32'd0, 64'd0));
    queue_cmd(make_cmd(MODE_DEL, 32'd123, 32'd0, 64'd0));
    queue_cmd(make_cmd(MODE_DEL, 32'd480, 32'd0, 64'd0));
    queue_cmd(make_cmd(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd5));
    queue_cmd(make_cmd(3'd7, 32'd1, 32'd1, 64'd1));
    write_tempo(32'hFFFF_FFFF);

    // Fill the table to capacity so that further adds are dropped.
    for (int k = 0; k < 70; k++)
      queue_cmd(make_cmd(MODE_ADD, 32'(k * 37 + 5), rand_tempo(), 64'd0));
    queue_cmd(make_cmd(MODE_ADD, 32'd1, 32'd9, 64'd0));
    queue_cmd(make_cmd(MODE_TTICK, 32'd0, 32'd0, rand_time()));
    write_tempo(32'd0);

    // Random phases; the predictor's table drives the delete targets.
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 100; k++) begin
        wait (pending_cmds.size() < 2);
        queue_cmd(rand_cmd());
      end
      write_tempo(ph == 3 ? RESET_TEMPO : $urandom());
    end
    wait_drained();
    if (errors == 0) begin
      $display("PASS tempo_map_table");
    end else begin
      $display("FAIL tempo_map_table");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("FAIL tempo_map_table");
    $finish;
  end

endmodule

FILE: sim.f
hdl/tmt_pkg.sv
hdl/tmt_cell.sv
hdl/tmt_mac.sv
hdl/tempo_map_table.sv
tb/tempo_map_table_test.sv
